>>> src/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

>>> src/gqu_pkg.sv
package gqu_pkg;

	localparam int LEVEL_BITS = 8;
	localparam int DATA_W     = 32;
	localparam int SUM_W      = 48;
	localparam int FRAC_W     = 16;
	localparam int DIVIDEND_W = DATA_W + FRAC_W;
	localparam int RATIO_FRAC = 30;
	localparam int PROD_W     = 2 * DATA_W;
	localparam int CFG_IDX_W  = 2;
	localparam int MAXLVL_W   = 8;
	localparam int USER_W     = 2;
	localparam int OUT_FIELDS_W = LEVEL_BITS + 3 * DATA_W + SUM_W;
	localparam int OUT_DATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

	typedef logic [LEVEL_BITS-1:0] level_t;
	typedef logic [DATA_W-1:0]     word_t;

	localparam level_t LEVEL_MAX = level_t'((1 << LEVEL_BITS) - 1);

	localparam word_t MIN_ERR_RESET      = 32'h0001_0000;
	localparam word_t GROWTH_RATIO_RESET = 32'h8000_0000;
	localparam logic [MAXLVL_W-1:0] MAX_LEVEL_RESET = 8'd255;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_ERR      = 2'd0,
		CFG_GROWTH_RATIO = 2'd1,
		CFG_MAX_LEVEL    = 2'd2
	} cfg_reg_t;

	// Flag positions inside the result tuser.
	localparam int USER_OVER_RANGE = 0;
	localparam int USER_ZERO_INPUT = 1;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		word_t                 divisor;
	} div_req_t;

	typedef struct packed {
		logic                  done;
		logic [DIVIDEND_W-1:0] quotient;
	} div_rsp_t;

endpackage

>>> src/gqu_ladder.sv
// One ladder step: registered product of the current value and the ratio,
// then a shift to Q16.16 with saturation to all ones.
module gqu_ladder (
	input  logic          clk,
	input  gqu_pkg::word_t value,
	input  gqu_pkg::word_t ratio,
	output gqu_pkg::word_t next_value
);
	import gqu_pkg::*;

	logic [PROD_W-1:0] product_s1;

	always_ff @(posedge clk) begin
		product_s1 <= PROD_W'(value) * PROD_W'(ratio);
	end

	// Anything above bit DATA_W + RATIO_FRAC - 1 no longer fits a Q16.16 word.
	assign next_value = (|product_s1[PROD_W-1:DATA_W+RATIO_FRAC]) ? '1
		: product_s1[DATA_W+RATIO_FRAC-1:RATIO_FRAC];

endmodule

>>> src/gqu_div.sv
// Restoring divider, one quotient bit per cycle, most significant first.
module gqu_div (
	input  logic              clk,
	input  logic              arst_n,
	input  gqu_pkg::div_req_t req,
	output gqu_pkg::div_rsp_t rsp
);
	import gqu_pkg::*;

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic [DATA_W-1:0]     rem_q;
	logic [DIVIDEND_W-1:0] quo_q;
	word_t                 divisor_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [DATA_W:0] trial;
	logic [DATA_W:0] diff;
	logic            fits;

	always_comb begin
		trial = {rem_q, quo_q[DIVIDEND_W-1]};
		diff  = trial - {1'b0, divisor_q};
		fits  = (trial >= {1'b0, divisor_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q     <= '0;
			quo_q     <= '0;
			divisor_q <= '0;
			cnt_q     <= '0;
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				rem_q     <= '0;
				quo_q     <= req.dividend;
				divisor_q <= req.divisor;
				cnt_q     <= CNT_W'(DIVIDEND_W);
				busy_q    <= 1'b1;
			end else if (busy_q) begin
				rem_q <= fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
				quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

>>> src/geometric_error_quantizer_unit.sv
// Geometric error quantizer.
// Input stream s_axis carries one Q16.16 error value per request. Output stream
// m_axis returns one result per request: the ladder level, its value, the
// relative error (q - x) / x, the running error sum and fitted count, with the
// over-range and zero-input flags in tuser.
// Configuration writes (cfg_index, cfg_data) are taken in any cycle and must
// only be issued while no request is in flight.
// A fitted value that lands on level k climbs the ladder in k steps and then
// goes through the divider for its ratio; an over-range value climbs to the top
// level only, and a zero input goes straight to the finish state. Each ladder
// level passes a check and a step state through the single multiplier, and the
// divider is bit-serial. One request is worked on at a time; the next is taken
// only once the sequencer is idle again, as it loads the result for output.
// s_axis_tready is high only while the sequencer is idle; a finished result
// sits in the output register, so the next request may start while the
// receiver stalls. A second result waits inside the block until the first
// is taken.
// Reset restores the register defaults, clears the error sum and the fitted
// count, and empties the output register.
module geometric_error_quantizer_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [gqu_pkg::DATA_W-1:0]       s_axis_tdata,  // error_value
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// level, quantized_value, error_ratio, error_total, fitted_total
	output logic [gqu_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	output logic [gqu_pkg::USER_W-1:0]       m_axis_tuser,  // over_range, zero_input
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [gqu_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gqu_pkg::DATA_W-1:0]       cfg_data
);
	import gqu_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_STEP,
		ST_DIVIDE,
		ST_FINISH
	} state_t;

	state_t state_q;

	word_t                min_err_q;
	word_t                growth_ratio_q;
	logic [MAXLVL_W-1:0]  max_level_q;

	word_t                x_q;
	word_t                q_q;
	level_t               k_q;
	level_t               top_q;
	logic                 over_q;
	logic                 zero_q;
	word_t                ratio_q;
	logic [SUM_W-1:0]     error_sum_q;
	word_t                fitted_count_q;

	logic                 out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic [USER_W-1:0]    out_user_q;

	word_t                ladder_next;
	div_req_t             div_req;
	div_rsp_t             div_rsp;

	logic                 in_fire;
	logic                 below_or_equal;
	logic                 keep_climbing;
	logic                 out_free;
	logic                 fitted;
	logic [15:0]          max_level_wide;
	level_t               top_next;
	logic [SUM_W:0]       sum_wide;
	logic [SUM_W-1:0]     sum_next;
	word_t                count_next;
	word_t                ratio_sat;

	gqu_ladder u_ladder (
		.clk        (clk),
		.value      (q_q),
		.ratio      (growth_ratio_q),
		.next_value (ladder_next)
	);

	gqu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		in_fire        = s_axis_tvalid && s_axis_tready;
		below_or_equal = (q_q <= x_q);
		keep_climbing  = below_or_equal && (k_q < top_q);
		out_free       = !out_valid_q || m_axis_tready;
		fitted         = !over_q && !zero_q;

		max_level_wide = 16'(max_level_q);
		top_next = (max_level_wide > 16'(LEVEL_MAX)) ? LEVEL_MAX
			: max_level_wide[LEVEL_BITS-1:0];

		div_req.start    = (state_q == ST_CHECK) && !below_or_equal;
		div_req.dividend = {q_q - x_q, {FRAC_W{1'b0}}};
		div_req.divisor  = x_q;

		ratio_sat = (|div_rsp.quotient[DIVIDEND_W-1:DATA_W]) ? '1
			: div_rsp.quotient[DATA_W-1:0];

		sum_wide   = {1'b0, error_sum_q} + (SUM_W + 1)'(ratio_q);
		sum_next   = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
		count_next = (&fitted_count_q) ? fitted_count_q : fitted_count_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			min_err_q      <= MIN_ERR_RESET;
			growth_ratio_q <= GROWTH_RATIO_RESET;
			max_level_q    <= MAX_LEVEL_RESET;
			x_q            <= '0;
			q_q            <= '0;
			k_q            <= '0;
			top_q          <= '0;
			over_q         <= 1'b0;
			zero_q         <= 1'b0;
			ratio_q        <= '0;
			error_sum_q    <= '0;
			fitted_count_q <= '0;
			out_valid_q    <= 1'b0;
			out_data_q     <= '0;
			out_user_q     <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_MIN_ERR:      min_err_q      <= cfg_data;
					CFG_GROWTH_RATIO: growth_ratio_q <= cfg_data;
					CFG_MAX_LEVEL:    max_level_q    <= cfg_data[MAXLVL_W-1:0];
					default: ;
				endcase
			end

			// In the finish state the output register is reloaded below instead.
			if (m_axis_tvalid && m_axis_tready && (state_q != ST_FINISH)) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						x_q     <= s_axis_tdata;
						q_q     <= min_err_q;
						k_q     <= '0;
						top_q   <= top_next;
						over_q  <= 1'b0;
						zero_q  <= (s_axis_tdata == '0);
						ratio_q <= '0;
						state_q <= (s_axis_tdata == '0) ? ST_FINISH : ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (keep_climbing) begin
						state_q <= ST_STEP;
					end else if (below_or_equal) begin
						over_q  <= 1'b1;
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_DIVIDE;
					end
				end
				ST_STEP: begin
					// The ladder unit captured q_q * ratio during the check cycle.
					q_q     <= ladder_next;
					k_q     <= k_q + 1'b1;
					state_q <= ST_CHECK;
				end
				ST_DIVIDE: begin
					if (div_rsp.done) begin
						ratio_q <= ratio_sat;
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						if (fitted) begin
							error_sum_q    <= sum_next;
							fitted_count_q <= count_next;
						end
						out_data_q <= OUT_DATA_W'({
							fitted ? count_next : fitted_count_q,
							fitted ? sum_next : error_sum_q,
							ratio_q, q_q, k_q});
						out_user_q <= {zero_q, over_q};
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;
	assign cfg_ready     = 1'b1;

endmodule

>>> src/gqu_checker.sv
`include "assert_macros.svh"

module gqu_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [gqu_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic [gqu_pkg::USER_W-1:0]     m_axis_tuser
);
	import gqu_pkg::*;

	localparam int RATIO_LO = LEVEL_BITS + DATA_W;

	logic flagged;
	assign flagged = m_axis_tuser[USER_OVER_RANGE] || m_axis_tuser[USER_ZERO_INPUT];

	// Taking a request leaves the sequencer busy, so s_axis_tready goes low.
	`ASSERT_NEXT(a_busy_after_request, clk, arst_n,
		s_axis_tvalid && s_axis_tready, !s_axis_tready)

	// A stalled result holds its payload.
	`ASSERT_NEXT(a_stall_holds, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

	// Flagged results carry no relative error.
	`ASSERT_IMPLIES(a_flag_no_ratio, clk, arst_n, m_axis_tvalid && flagged,
		m_axis_tdata[RATIO_LO+DATA_W-1:RATIO_LO] == '0)

	// A zero input always lands on the bottom level and is never over range.
	`ASSERT_IMPLIES(a_zero_bottom, clk, arst_n,
		m_axis_tvalid && m_axis_tuser[USER_ZERO_INPUT],
		(m_axis_tdata[LEVEL_BITS-1:0] == '0) && !m_axis_tuser[USER_OVER_RANGE])

endmodule

bind geometric_error_quantizer_unit gqu_checker u_gqu_checker (.*);
